>>> rtl/core/ehk_pkg.sv
// ----------------------------------------------------------------------------
// ehk_pkg: shared types and constants of the element Hilbert key block
// Field widths, fixed-point split points, register codes and the structs that
// travel between the front end, the quantiser and the Hilbert cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ehk_pkg;

   // Stream payload widths
   localparam int unsigned TAG_W       = 32;
   localparam int unsigned VERT_W      = 32;
   localparam int unsigned VERT_SLOTS  = 4;
   localparam int unsigned REQ_DATA_W  = TAG_W + 2 * VERT_SLOTS * VERT_W;
   localparam int unsigned CELL_W      = 15;
   localparam int unsigned KEY_W       = 30;
   localparam int unsigned RSP_FIELD_W = TAG_W + KEY_W + 2 * CELL_W + 1;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // Vertex count handling
   localparam int unsigned MIN_VERTS = 3;
   localparam int unsigned MAX_VERTS = 4;
   localparam int unsigned CNT_W     = 3;

   // Arithmetic widths
   localparam int unsigned SUM_W      = 34;
   localparam int unsigned OFFSET_W   = 36;
   localparam int unsigned DIFF_W     = 37;
   localparam int unsigned MAG_W      = 36;
   localparam int unsigned MAG_HALF   = MAG_W / 2;
   localparam int unsigned SCALE_W    = 48;
   localparam int unsigned SCALE_HALF = SCALE_W / 2;
   localparam int unsigned PP_W       = MAG_HALF + SCALE_HALF;
   localparam int unsigned PART_W     = PP_W + MAG_HALF + 1;
   localparam int unsigned PROD_W     = PART_W + SCALE_HALF;
   localparam int unsigned FRAC_BITS  = 40;

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [CNT_W-1:0]   VERTEX_COUNT_RESET = CNT_W'(4);
   localparam logic [SCALE_W-1:0] SCALE_RESET        = SCALE_W'(64'd16777216);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERTEX_COUNT  = 2'd0,
      CSR_SUM_OFFSET_X  = 2'd1,
      CSR_SUM_OFFSET_Y  = 2'd2,
      CSR_LATTICE_SCALE = 2'd3
   } csr_index_type;

   // Settled configuration as seen by the datapath; index 0 is x, 1 is y.
   typedef struct packed {
      logic                          four_verts;
      logic [1:0][OFFSET_W-1:0]      offset;
      logic [SCALE_W-1:0]            scale;
   } csr_cfg_type;

   // Result fields that ride along the Hilbert cell row unchanged.
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic              clipped;
   } cell_meta_type;

endpackage

>>> rtl/core/ehk_front.sv
// ----------------------------------------------------------------------------
// ehk_front: vertex summation and offset removal
// Two stages: sum of three or four vertex coordinates per axis, then the
// configured offset is subtracted and split into the sign bit and the low bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehk_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ehk_pkg::csr_cfg_type                  cfg,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [ehk_pkg::REQ_DATA_W-1:0]        in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [ehk_pkg::TAG_W-1:0]             out_tag,
   output logic [1:0]                            out_neg,
   output logic [1:0][ehk_pkg::MAG_W-1:0]        out_mag
);
   import ehk_pkg::*;

   logic                         s1_valid_ff, s1_valid_in, s1_ready;
   logic [TAG_W-1:0]             s1_tag_ff, s1_tag_in;
   logic [1:0][SUM_W-1:0]        s1_sum_ff, s1_sum_in;
   logic                         s2_valid_ff, s2_valid_in, s2_ready;
   logic [TAG_W-1:0]             s2_tag_ff, s2_tag_in;
   logic [1:0]                   s2_neg_ff, s2_neg_in;
   logic [1:0][MAG_W-1:0]        s2_mag_ff, s2_mag_in;
   logic [1:0][DIFF_W-1:0]       diff;

   // Each stage takes new data when it is empty or its contents move on.
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s1_tag_in = s1_ready ? in_data[TAG_W-1:0] : s1_tag_ff;
      for (int a = 0; a < 2; a++) begin
         s1_sum_in[a] = '0;
         for (int k = 0; k < VERT_SLOTS; k++) begin
            if (k < MIN_VERTS || cfg.four_verts) begin
               s1_sum_in[a] = s1_sum_in[a]
                  + SUM_W'($signed(in_data[TAG_W + (2 * k + a) * VERT_W +: VERT_W]));
            end
         end
         if (!s1_ready) begin
            s1_sum_in[a] = s1_sum_ff[a];
         end
      end
   end

   always_comb begin
      s2_tag_in = s2_ready ? s1_tag_ff : s2_tag_ff;
      for (int a = 0; a < 2; a++) begin
         diff[a] = DIFF_W'($signed(s1_sum_ff[a])) - DIFF_W'($signed(cfg.offset[a]));
         s2_neg_in[a] = s2_ready ? diff[a][DIFF_W-1] : s2_neg_ff[a];
         s2_mag_in[a] = s2_ready ? diff[a][MAG_W-1:0] : s2_mag_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= s1_tag_in;
      s1_sum_ff <= s1_sum_in;
      s2_tag_ff <= s2_tag_in;
      s2_neg_ff <= s2_neg_in;
      s2_mag_ff <= s2_mag_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_tag   = s2_tag_ff;
   assign out_neg   = s2_neg_ff;
   assign out_mag   = s2_mag_ff;

endmodule

>>> rtl/core/ehk_quant.sv
// ----------------------------------------------------------------------------
// ehk_quant: scaling, flooring and saturation to lattice cells
// Three stages: four 18 x 24 partial products per axis, two partial sums,
// then the final sum with floor, saturation and the clip flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehk_quant #(
   parameter int unsigned LATTICE_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ehk_pkg::csr_cfg_type               cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [ehk_pkg::TAG_W-1:0]          in_tag,
   input  logic [1:0]                         in_neg,
   input  logic [1:0][ehk_pkg::MAG_W-1:0]     in_mag,
   output logic                               out_valid,
   input  logic                               out_ready,
   output ehk_pkg::cell_meta_type             out_meta,
   output logic [LATTICE_BITS-1:0]            out_x,
   output logic [LATTICE_BITS-1:0]            out_y
);
   import ehk_pkg::*;

   localparam int unsigned LB = LATTICE_BITS;

   logic                      q1_valid_ff, q1_valid_in, q1_ready;
   logic [TAG_W-1:0]          q1_tag_ff, q1_tag_in;
   logic [1:0]                q1_neg_ff, q1_neg_in;
   logic [1:0][PP_W-1:0]      q1_ll_ff, q1_ll_in, q1_lh_ff, q1_lh_in;
   logic [1:0][PP_W-1:0]      q1_hl_ff, q1_hl_in, q1_hh_ff, q1_hh_in;
   logic                      q2_valid_ff, q2_valid_in, q2_ready;
   logic [TAG_W-1:0]          q2_tag_ff, q2_tag_in;
   logic [1:0]                q2_neg_ff, q2_neg_in;
   logic [1:0][PART_W-1:0]    q2_lo_ff, q2_lo_in, q2_hi_ff, q2_hi_in;
   logic                      q3_valid_ff, q3_valid_in, q3_ready;
   logic [TAG_W-1:0]          q3_tag_ff, q3_tag_in;
   logic [1:0][LB-1:0]        q3_cell_ff, q3_cell_in;
   logic                      q3_clip_ff, q3_clip_in;
   logic [1:0][PROD_W-1:0]    prod;
   logic [1:0]                over;
   logic [LB+CELL_W-1:0]      wide_x, wide_y;
   logic                      scale_zero;

   assign q3_ready = !q3_valid_ff || out_ready;
   assign q2_ready = !q2_valid_ff || q3_ready;
   assign q1_ready = !q1_valid_ff || q2_ready;
   assign in_ready = q1_ready;

   assign q1_valid_in = q1_ready ? in_valid : q1_valid_ff;
   assign q2_valid_in = q2_ready ? q1_valid_ff : q2_valid_ff;
   assign q3_valid_in = q3_ready ? q2_valid_ff : q3_valid_ff;

   // A zero scale gives cell zero without clipping, even for a negative sum.
   assign scale_zero = (cfg.scale == '0);

   always_comb begin
      q1_tag_in = q1_ready ? in_tag : q1_tag_ff;
      for (int a = 0; a < 2; a++) begin
         q1_neg_in[a] = q1_ready ? (in_neg[a] && !scale_zero) : q1_neg_ff[a];
         q1_ll_in[a]  = q1_ready ? PP_W'(in_mag[a][MAG_HALF-1:0])
                                   * PP_W'(cfg.scale[SCALE_HALF-1:0]) : q1_ll_ff[a];
         q1_lh_in[a]  = q1_ready ? PP_W'(in_mag[a][MAG_HALF-1:0])
                                   * PP_W'(cfg.scale[SCALE_W-1:SCALE_HALF]) : q1_lh_ff[a];
         q1_hl_in[a]  = q1_ready ? PP_W'(in_mag[a][MAG_W-1:MAG_HALF])
                                   * PP_W'(cfg.scale[SCALE_HALF-1:0]) : q1_hl_ff[a];
         q1_hh_in[a]  = q1_ready ? PP_W'(in_mag[a][MAG_W-1:MAG_HALF])
                                   * PP_W'(cfg.scale[SCALE_W-1:SCALE_HALF]) : q1_hh_ff[a];
      end
   end

   always_comb begin
      q2_tag_in = q2_ready ? q1_tag_ff : q2_tag_ff;
      for (int a = 0; a < 2; a++) begin
         q2_neg_in[a] = q2_ready ? q1_neg_ff[a] : q2_neg_ff[a];
         q2_lo_in[a]  = q2_ready ? PART_W'(q1_ll_ff[a]) + (PART_W'(q1_hl_ff[a]) << MAG_HALF)
                                 : q2_lo_ff[a];
         q2_hi_in[a]  = q2_ready ? PART_W'(q1_lh_ff[a]) + (PART_W'(q1_hh_ff[a]) << MAG_HALF)
                                 : q2_hi_ff[a];
      end
   end

   // The product is Q45.40; cells are its integer part, saturated.
   always_comb begin
      q3_tag_in  = q3_ready ? q2_tag_ff : q3_tag_ff;
      q3_clip_in = q3_clip_ff;
      q3_cell_in = q3_cell_ff;
      for (int a = 0; a < 2; a++) begin
         prod[a] = PROD_W'(q2_lo_ff[a]) + (PROD_W'(q2_hi_ff[a]) << SCALE_HALF);
         over[a] = |prod[a][PROD_W-1:FRAC_BITS+LB];
      end
      if (q3_ready) begin
         q3_clip_in = |(q2_neg_ff | over);
         for (int a = 0; a < 2; a++) begin
            if (q2_neg_ff[a]) begin
               q3_cell_in[a] = '0;
            end else if (over[a]) begin
               q3_cell_in[a] = '1;
            end else begin
               q3_cell_in[a] = prod[a][FRAC_BITS +: LB];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
         q2_valid_ff <= 1'b0;
         q3_valid_ff <= 1'b0;
      end else begin
         q1_valid_ff <= q1_valid_in;
         q2_valid_ff <= q2_valid_in;
         q3_valid_ff <= q3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q1_tag_ff  <= q1_tag_in;
      q1_neg_ff  <= q1_neg_in;
      q1_ll_ff   <= q1_ll_in;
      q1_lh_ff   <= q1_lh_in;
      q1_hl_ff   <= q1_hl_in;
      q1_hh_ff   <= q1_hh_in;
      q2_tag_ff  <= q2_tag_in;
      q2_neg_ff  <= q2_neg_in;
      q2_lo_ff   <= q2_lo_in;
      q2_hi_ff   <= q2_hi_in;
      q3_tag_ff  <= q3_tag_in;
      q3_cell_ff <= q3_cell_in;
      q3_clip_ff <= q3_clip_in;
   end

   assign wide_x = {{CELL_W{1'b0}}, q3_cell_ff[0]};
   assign wide_y = {{CELL_W{1'b0}}, q3_cell_ff[1]};

   assign out_valid        = q3_valid_ff;
   assign out_meta.tag     = q3_tag_ff;
   assign out_meta.cell_x  = wide_x[CELL_W-1:0];
   assign out_meta.cell_y  = wide_y[CELL_W-1:0];
   assign out_meta.clipped = q3_clip_ff;
   assign out_x            = q3_cell_ff[0];
   assign out_y            = q3_cell_ff[1];

endmodule

>>> rtl/core/ehk_cell.sv
// ----------------------------------------------------------------------------
// ehk_cell: one quadrant stage of the Hilbert encoder
// Reads the coordinate bits at its level, adds the quadrant digit to the key,
// then drops those bits and rotates or reflects the remaining sub-square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehk_cell #(
   parameter int unsigned LATTICE_BITS = 15,
   parameter int unsigned LEVEL        = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  ehk_pkg::cell_meta_type           in_meta,
   input  logic [LATTICE_BITS-1:0]          in_x,
   input  logic [LATTICE_BITS-1:0]          in_y,
   input  logic [2*LATTICE_BITS-1:0]        in_key,
   output logic                             out_valid,
   input  logic                             out_ready,
   output ehk_pkg::cell_meta_type           out_meta,
   output logic [LATTICE_BITS-1:0]          out_x,
   output logic [LATTICE_BITS-1:0]          out_y,
   output logic [2*LATTICE_BITS-1:0]        out_key
);
   import ehk_pkg::*;

   localparam int unsigned      LB       = LATTICE_BITS;
   localparam logic [LB-1:0]    LOW_MASK = {LB{1'b1}} >> (LB - LEVEL);

   logic                  valid_ff, valid_in, ready;
   cell_meta_type         meta_ff, meta_in;
   logic [LB-1:0]         x_ff, x_in, y_ff, y_in, xm, ym;
   logic [2*LB-1:0]       key_ff, key_in;
   logic                  rx, ry;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;
   assign valid_in = ready ? in_valid : valid_ff;

   always_comb begin
      rx = in_x[LEVEL];
      ry = in_y[LEVEL];
      xm = in_x & LOW_MASK;
      ym = in_y & LOW_MASK;
      if (!ry && rx) begin
         xm = ~xm & LOW_MASK;
         ym = ~ym & LOW_MASK;
      end
      meta_in = meta_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      key_in  = key_ff;
      if (ready) begin
         meta_in = in_meta;
         x_in    = ry ? xm : ym;
         y_in    = ry ? ym : xm;
         // Quadrant digit: 0, 1, 3, 2 for (rx, ry) = 00, 01, 10, 11.
         key_in  = in_key | ({{(2*LB-2){1'b0}}, rx, rx ^ ry} << (2 * LEVEL));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      key_ff  <= key_in;
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_key   = key_ff;

endmodule

>>> rtl/core/element_hilbert_key_top.sv
// ----------------------------------------------------------------------------
// element_hilbert_key_top: Hilbert curve sort key for 2D mesh elements
// Each transfer on the req_ channel carries one element: its index and the
// x/y coordinates of four vertices in signed Q16.16. The block sums three or
// four vertices per axis, removes the configured offset, scales by the Q24.24
// lattice factor, floors and saturates to lattice cells and encodes the cell
// as a Hilbert distance. Every request gives exactly one transfer on rsp_,
// in order. The csr_ port writes the four registers; write it only while no
// element is in flight.
// An element passes the summation stages, the scaling and saturation stages and
// then the row of Hilbert cells. Throughput is one element per cycle while
// rsp_tready is high; every stage and cell is a register with its own valid
// bit, so bubbles close up and req_tready stays high while a finished result
// waits, until the pipeline is actually full.
// When rsp_tready is low, rsp_tvalid and rsp_tdata hold. Reset empties the
// pipeline and returns vertex_count to 4, both offsets to 0 and the scale
// to 1.0; no transfer is lost or repeated through a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module element_hilbert_key_top #(
   parameter int unsigned LATTICE_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // element_index, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
   // vert3_x, vert3_y (32 bits each, lowest bits first)
   input  logic [ehk_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // element_tag (32), hilbert_key (30), cell_x (15), cell_y (15),
   // clipped (1), then three zero bits
   output logic [ehk_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Register write port
   input  logic                               csr_we,
   input  logic [ehk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ehk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ehk_pkg::*;

   localparam int unsigned LB = LATTICE_BITS;

   // Configuration registers.
   logic [CNT_W-1:0]      vertex_count_ff, vertex_count_in;
   logic [OFFSET_W-1:0]   offset_x_ff, offset_x_in;
   logic [OFFSET_W-1:0]   offset_y_ff, offset_y_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;
   csr_cfg_type           cfg;

   // Front end to quantiser.
   logic                  fr_valid, fr_ready;
   logic [TAG_W-1:0]      fr_tag;
   logic [1:0]            fr_neg;
   logic [1:0][MAG_W-1:0] fr_mag;

   // Hilbert cell row: entry 0 is fed by the quantiser, entry LB is the output.
   logic                  hc_valid [LB+1];
   logic                  hc_ready [LB+1];
   cell_meta_type         hc_meta  [LB+1];
   logic [LB-1:0]         hc_x     [LB+1];
   logic [LB-1:0]         hc_y     [LB+1];
   logic [2*LB-1:0]       hc_key   [LB+1];

   logic [2*LB+KEY_W-1:0] wide_key;
   cell_meta_type         rsp_meta;
   logic [KEY_W-1:0]      rsp_key;

   // Register writes; an index outside the list leaves everything unchanged.
   always_comb begin
      vertex_count_in = vertex_count_ff;
      offset_x_in     = offset_x_ff;
      offset_y_in     = offset_y_ff;
      scale_in        = scale_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VERTEX_COUNT:  vertex_count_in = csr_wdata[CNT_W-1:0];
            CSR_SUM_OFFSET_X:  offset_x_in     = csr_wdata[OFFSET_W-1:0];
            CSR_SUM_OFFSET_Y:  offset_y_in     = csr_wdata[OFFSET_W-1:0];
            CSR_LATTICE_SCALE: scale_in        = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         offset_x_ff     <= '0;
         offset_y_ff     <= '0;
         scale_ff        <= SCALE_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
         offset_x_ff     <= offset_x_in;
         offset_y_ff     <= offset_y_in;
         scale_ff        <= scale_in;
      end
   end

   // A count of three or less sums three vertices, anything above sums four.
   assign cfg.four_verts = (MAX_VERTS > MIN_VERTS) && (vertex_count_ff > CNT_W'(MIN_VERTS));
   assign cfg.offset[0]  = offset_x_ff;
   assign cfg.offset[1]  = offset_y_ff;
   assign cfg.scale      = scale_ff;

   ehk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_tag   (fr_tag),
      .out_neg   (fr_neg),
      .out_mag   (fr_mag)
   );

   ehk_quant #(
      .LATTICE_BITS (LB)
   ) u_quant (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_tag    (fr_tag),
      .in_neg    (fr_neg),
      .in_mag    (fr_mag),
      .out_valid (hc_valid[0]),
      .out_ready (hc_ready[0]),
      .out_meta  (hc_meta[0]),
      .out_x     (hc_x[0]),
      .out_y     (hc_y[0])
   );

   assign hc_key[0] = '0;

   // One cell per lattice bit, most significant level first.
   for (genvar k = 0; k < LB; k++) begin : g_cell
      ehk_cell #(
         .LATTICE_BITS (LB),
         .LEVEL        (LB - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (hc_valid[k]),
         .in_ready  (hc_ready[k]),
         .in_meta   (hc_meta[k]),
         .in_x      (hc_x[k]),
         .in_y      (hc_y[k]),
         .in_key    (hc_key[k]),
         .out_valid (hc_valid[k+1]),
         .out_ready (hc_ready[k+1]),
         .out_meta  (hc_meta[k+1]),
         .out_x     (hc_x[k+1]),
         .out_y     (hc_y[k+1]),
         .out_key   (hc_key[k+1])
      );
   end

   // The last cell's register is the output register.
   assign hc_ready[LB] = rsp_tready;
   assign rsp_tvalid   = hc_valid[LB];
   assign rsp_meta     = hc_meta[LB];
   assign wide_key     = {{KEY_W{1'b0}}, hc_key[LB]};
   assign rsp_key      = wide_key[KEY_W-1:0];
   assign rsp_tdata    = {{RSP_PAD_W{1'b0}}, rsp_meta.clipped, rsp_meta.cell_y,
                          rsp_meta.cell_x, rsp_key, rsp_meta.tag};

`ifndef SYNTHESIS
   // With the output register empty every stage can pass its contents on, so a
   // request must be taken.
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while the output register is empty");

   a_reset_flush: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   // The curve starts at the origin and visits no other cell at distance zero.
   a_origin_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_meta.cell_x == '0 && rsp_meta.cell_y == '0) |-> rsp_key == '0)
      else $error("origin cell produced a non-zero Hilbert key");
`endif

endmodule

>>> bench/element_hilbert_key_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// element_hilbert_key_top_tb: self-checking bench for the element Hilbert key
// A directed table of elements followed by randomised phases, each under its
// own register setting. Every accepted element has an expected result, typed in
// or predicted bit for bit, and each response transfer is compared field by
// field with the oldest pending key. Both streams idle at random, and one long
// receiver hold-off fills the pipeline so that the request side has to stall.
// ----------------------------------------------------------------------------

module element_hilbert_key_top_tb;

   import ehk_pkg::*;

   // Pipeline depth at the default lattice size: five arithmetic stages plus
   // one Hilbert cell per lattice bit.
   localparam int PIPE_LATENCY   = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 92;
   localparam int PHASE_COUNT    = 8;
   localparam int DIRECTED_COUNT = 20;

   localparam logic [14:0] CELL_MAX  = 15'h7FFF;
   localparam logic [47:0] SCALE_ONE = 48'h0000_0100_0000;
   localparam logic [47:0] SCALE_TOP = 48'hFFFF_FFFF_FFFF;

   // One mesh element as it travels on the request stream.
   typedef struct packed {
      logic [31:0]       tag;
      logic [3:0][31:0]  vx;
      logic [3:0][31:0]  vy;
   } mesh_element_type;

   // One decoded response transfer.
   typedef struct packed {
      logic [31:0] tag;
      logic [29:0] key;
      logic [14:0] cx;
      logic [14:0] cy;
      logic        clip;
   } key_result_type;

   // A directed row: the register setting it runs under, the element, and a
   // typed-in key where one can be read off directly.  Vertices 0 to 2 share
   // one coordinate pair; vertex 3 has its own so that it can be told apart.
   typedef struct packed {
      logic [2:0]  vc;
      logic [35:0] off_x;
      logic [35:0] off_y;
      logic [47:0] scale;
      logic [31:0] tag;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] v3x;
      logic [31:0] v3y;
      logic        has_exp;
      logic [29:0] key;
      logic [14:0] cx;
      logic [14:0] cy;
      logic        clip;
   } directed_row_type;

   // ------------------------------------------------------------------------
   // Signals to and from the block; every input starts at a known value.
   // ------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the registers as the predictor sees them.
   logic [2:0]  cfg_vcount = 3'd4;
   logic [35:0] cfg_off_x  = '0;
   logic [35:0] cfg_off_y  = '0;
   logic [47:0] cfg_scale  = SCALE_ONE;

   key_result_type pending_keys[$];
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   int          stall_left     = 0;
   bit          quiet          = 1'b0;
   bit          hold_request   = 1'b0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Zero element straight after reset: cell 0, key 0.
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 1'b1, 30'h0, 15'h0, 15'h0, 1'b0},
      // Most negative coordinates on both axes clip to cell 0.
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 1'b1, 30'h0, 15'h0, 15'h0, 1'b1},
      // Most positive x saturates to the top cell, which ends the curve.
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000,
        32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 30'h3FFF_FFFF, CELL_MAX, 15'h0, 1'b1},
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0002, 32'h0001_0000, 32'h0002_0000,
        32'h0001_0000, 32'h0002_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0003, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0004, 32'h0000_1000, 32'h0000_0FFF,
        32'h0000_1000, 32'h0000_0FFF, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      // Just below and just above the top of the lattice.
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0005, 32'h1FFF_FFFF, 32'h2000_0000,
        32'h1FFF_FFFF, 32'h2000_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd4, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0006, 32'h7FFF_FFFF, 32'h0000_8000,
        32'h8000_0000, 32'hFFFF_8000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      // Triangles: vertex 3 carries extremes that must be ignored.
      '{3'd3, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0007, 32'h0001_0000, 32'h0003_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      // Out-of-range counts fold to three below four and to four above.
      '{3'd0, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0008, 32'h0001_0000, 32'h0003_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd7, 36'h0, 36'h0, SCALE_ONE, 32'h0000_0009, 32'h0001_0000, 32'h0003_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd5, 36'h0, 36'h0, SCALE_ONE, 32'h0000_000A, 32'h0001_0000, 32'h0003_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      // Offset cancels the sum exactly: zero difference, no clipping.
      '{3'd4, 36'h0_0004_0000, 36'h0, SCALE_ONE, 32'h0000_000B, 32'h0001_0000,
        32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 30'h0, 15'h0, 15'h0, 1'b0},
      // Offset extremes: x pushed far up, y far down.
      '{3'd4, 36'h8_0000_0000, 36'h7_FFFF_FFFF, SCALE_ONE, 32'h0000_000C, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 30'h3FFF_FFFF, CELL_MAX,
        15'h0, 1'b1},
      '{3'd4, 36'h8_0000_0000, 36'h7_FFFF_FFFF, SCALE_ONE, 32'h0000_000D, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      // A zero scale gives cell 0 without clipping, whatever the sign.
      '{3'd4, 36'h0, 36'h0, 48'h0, 32'h0000_000E, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd4, 36'h0, 36'h0, 48'h0, 32'h0000_000F, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 1'b1, 30'h0, 15'h0, 15'h0, 1'b0},
      // Largest scale on tiny coordinates.
      '{3'd4, 36'h0, 36'h0, SCALE_TOP, 32'h0000_0010, 32'h0000_0001, 32'h0000_0000,
        32'h0000_0001, 32'h0000_0000, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      '{3'd4, 36'h0, 36'h0, SCALE_TOP, 32'h0000_0011, 32'h0000_0010, 32'h0000_0020,
        32'h0000_0010, 32'h0000_0020, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0},
      // Smallest non-zero scale with a negative offset: floors to 0 unclipped.
      '{3'd4, 36'hF_FFFC_0000, 36'h0, 48'h1, 32'h0000_0012, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 30'h0, 15'h0, 15'h0, 1'b0}
   };

   element_hilbert_key_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Floor of diff * scale / 2^40, saturated into the lattice.  A zero scale
   // or zero difference wins over the sign test, so it never clips.
   function automatic logic [14:0] quantise(input logic signed [36:0] diff,
                                            input logic [47:0] scale,
                                            inout bit clip);
      logic [36:0] mag;
      logic [84:0] prod;
      if (diff == 0 || scale == 0)
         return 15'h0;
      if (diff < 0) begin
         clip = 1'b1;
         return 15'h0;
      end
      mag  = diff;
      prod = mag * scale;
      if ((prod >> 40) > CELL_MAX) begin
         clip = 1'b1;
         return CELL_MAX;
      end
      return prod[54:40];
   endfunction

   // Distance along the curve, one quadrant rotate and flip per lattice bit.
   function automatic logic [29:0] hilbert_distance(input logic [14:0] cell_x,
                                                    input logic [14:0] cell_y);
      logic [14:0] x, y, s, t;
      logic [29:0] d;
      logic [1:0]  quad;
      bit          rx, ry;
      x = cell_x;
      y = cell_y;
      d = '0;
      for (int lvl = 14; lvl >= 0; lvl--) begin
         s    = 15'd1 << lvl;
         rx   = x[lvl];
         ry   = y[lvl];
         quad = {rx, rx ^ ry};
         d    = d + (30'(quad) << (2 * lvl));
         x    = x & (s - 15'd1);
         y    = y & (s - 15'd1);
         if (!ry) begin
            if (rx) begin
               x = (s - 15'd1) - x;
               y = (s - 15'd1) - y;
            end
            t = x;
            x = y;
            y = t;
         end
      end
      return d;
   endfunction

   function automatic key_result_type predict_key(input mesh_element_type e);
      int                 n_verts;
      logic signed [36:0] sum_x, sum_y;
      bit                 clip;
      key_result_type     r;
      n_verts = (cfg_vcount <= 3'd3) ? 3 : 4;
      sum_x   = '0;
      sum_y   = '0;
      for (int k = 0; k < n_verts; k++) begin
         sum_x = sum_x + $signed(e.vx[k]);
         sum_y = sum_y + $signed(e.vy[k]);
      end
      sum_x  = sum_x - $signed(cfg_off_x);
      sum_y  = sum_y - $signed(cfg_off_y);
      clip   = 1'b0;
      r.tag  = e.tag;
      r.cx   = quantise(sum_x, cfg_scale, clip);
      r.cy   = quantise(sum_y, cfg_scale, clip);
      r.key  = hilbert_distance(r.cx, r.cy);
      r.clip = clip;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly back-to-back, now and then a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A start point for a box of the given span that stays inside Q16.16.
   function automatic longint pick_base(input longint span);
      longint b;
      b = longint'($signed($urandom));
      if (b + span > 64'sd2147483647)
         b = b - span;
      return b;
   endfunction

   task automatic write_register(input csr_index_type idx, input logic [47:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_VERTEX_COUNT:  cfg_vcount = data[2:0];
         CSR_SUM_OFFSET_X:  cfg_off_x  = data[35:0];
         CSR_SUM_OFFSET_Y:  cfg_off_y  = data[35:0];
         CSR_LATTICE_SCALE: cfg_scale  = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Drops the request valid, lets every pending key come back, then writes
   // all four registers while nothing is in flight.  Every element gives a
   // result, so an empty store means an empty pipeline.
   task automatic apply_config(input logic [47:0] vc_word, input logic [47:0] off_x_word,
                               input logic [47:0] off_y_word, input logic [47:0] scale_word);
      req_tvalid <= 1'b0;
      while (pending_keys.size() != 0)
         @(posedge clock);
      write_register(CSR_VERTEX_COUNT, vc_word);
      write_register(CSR_SUM_OFFSET_X, off_x_word);
      write_register(CSR_SUM_OFFSET_Y, off_y_word);
      write_register(CSR_LATTICE_SCALE, scale_word);
      csr_we <= 1'b0;
   endtask

   // Offers one element and holds it until the transfer happens.  With a gap
   // of zero the valid stays high for the next element, so it is never
   // lowered and raised again within one time step.
   task automatic send_element(input mesh_element_type e, input key_result_type want,
                               input int gap);
      logic [REQ_DATA_W-1:0] word;
      word        = '0;
      word[31:0]  = e.tag;
      for (int k = 0; k < 4; k++) begin
         word[32 + 64 * k +: 32] = e.vx[k];
         word[64 + 64 * k +: 32] = e.vy[k];
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_keys.push_back(want);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input longint got, input longint want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   // Each response transfer is compared with the oldest pending key.
   always @(posedge clock) begin : result_check
      key_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_keys.size() == 0) begin
            report_mismatch("response with no element pending", rsp_tdata[31:0], 0);
         end else begin
            want = pending_keys.pop_front();
            check_field("element_tag", rsp_tdata[31:0], want.tag);
            check_field("hilbert_key", rsp_tdata[61:32], want.key);
            check_field("cell_x", rsp_tdata[76:62], want.cx);
            check_field("cell_y", rsp_tdata[91:77], want.cy);
            check_field("clipped", rsp_tdata[92], want.clip);
            check_field("padding", rsp_tdata[RSP_DATA_W-1:93], 0);
         end
      end
   end

   // The receiver idles at random; on request it holds off for a long
   // stretch so that the pipeline fills and the request side stalls.
   always @(posedge clock) begin : receiver
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         rsp_tready   <= 1'b0;
         stall_left    = HOLD_CYCLES;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         g = pick_gap();
         if (g == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left  = g - 1;
         end
      end
   end

   // Watchdog: a run of cycles with no transfer on either stream is a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed table, random phases, drain, verdict.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      mesh_element_type e;
      key_result_type   want;
      directed_row_type row;
      longint        span, base_x, base_y;
      logic [127:0]  wide;
      logic [47:0]   vc_w, off_x_w, off_y_w, scale_w;
      logic [2:0]    vc;
      int            n_verts, style;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the first rows run on the reset values of the
      // registers; a change of setting in the table forces a drain and a
      // fresh write of all four registers.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         if (row.vc != cfg_vcount || row.off_x != cfg_off_x || row.off_y != cfg_off_y ||
             row.scale != cfg_scale)
            apply_config(48'(row.vc), 48'(row.off_x), 48'(row.off_y), row.scale);
         e.tag = row.tag;
         for (int k = 0; k < 3; k++) begin
            e.vx[k] = row.vx;
            e.vy[k] = row.vy;
         end
         e.vx[3] = row.v3x;
         e.vy[3] = row.v3y;
         if (row.has_exp)
            want = '{row.tag, row.key, row.cx, row.cy, row.clip};
         else
            want = predict_key(e);
         send_element(e, want, pick_gap());
      end

      // Random phases.  Most elements lie in a box whose offset and scale
      // map it onto the whole lattice; the rest are raw noise and extremes.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0, 5:    vc = 3'd4;
            1:       vc = 3'd3;
            2:       vc = 3'd0;
            3:       vc = 3'd7;
            4:       vc = 3'd5;
            default: vc = 3'($urandom_range(0, 7));
         endcase
         n_verts = (vc <= 3'd3) ? 3 : 4;
         span    = (64'sd1 << $urandom_range(10, 28)) + $urandom_range(0, 1023);
         base_x  = pick_base(span);
         base_y  = pick_base(span);
         wide    = (128'd32767 << 40) / 128'(longint'(n_verts) * span);
         if (p == 7)
            wide = wide * 2;   // about half of the box lands past the top
         if (wide > 128'(SCALE_TOP))
            wide = 128'(SCALE_TOP);
         // Upper data bits beyond each register are random and must be dropped.
         vc_w    = {13'($urandom), $urandom, vc};
         off_x_w = {12'($urandom), 36'(longint'(n_verts) * base_x)};
         off_y_w = {12'($urandom), 36'(longint'(n_verts) * base_y)};
         scale_w = wide[47:0];
         if (p == 6) begin
            off_x_w = {16'($urandom), $urandom};
            off_y_w = {16'($urandom), $urandom};
            scale_w = {16'($urandom), $urandom};
         end
         apply_config(vc_w, off_x_w, off_y_w, scale_w);
         quiet = (p == 5);
         if (p == 2)
            hold_request <= 1'b1;

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            e.tag = $urandom;
            style = $urandom_range(0, 99);
            for (int k = 0; k < 4; k++) begin
               if (style < 90) begin
                  e.vx[k] = 32'(base_x + longint'($urandom_range(0, 32'(span))));
                  e.vy[k] = 32'(base_y + longint'($urandom_range(0, 32'(span))));
               end else if (style < 95) begin
                  e.vx[k] = $urandom;
                  e.vy[k] = $urandom;
               end else begin
                  case ($urandom_range(0, 3))
                     0:       e.vx[k] = 32'h8000_0000;
                     1:       e.vx[k] = 32'h7FFF_FFFF;
                     2:       e.vx[k] = 32'h0000_0000;
                     default: e.vx[k] = $urandom;
                  endcase
                  case ($urandom_range(0, 3))
                     0:       e.vy[k] = 32'h8000_0000;
                     1:       e.vy[k] = 32'h7FFF_FFFF;
                     2:       e.vy[k] = 32'h0000_0000;
                     default: e.vy[k] = $urandom;
                  endcase
               end
            end
            send_element(e, predict_key(e), pick_gap());
         end
      end

      // Drain: every pending key must come back, then the bench waits on so that any
      // stray transfer can show up.
      quiet       = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_keys.size() != 0)
         @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/ehk_pkg.sv
rtl/core/ehk_front.sv
rtl/core/ehk_quant.sv
rtl/core/ehk_cell.sv
rtl/core/element_hilbert_key_top.sv
bench/element_hilbert_key_top_tb.sv
